// ===== hw/rtl/rtcm3_ftm_pkg.sv =====
// Shared types, constants and functions for the RTCM3 frame type monitor.
package rtcm3_ftm_pkg;

  localparam logic [7:0]  Preamble   = 8'hD3;
  localparam logic [23:0] Crc24qPoly = 24'h864CFB;  // 0x1864CFB without the x^24 term
  localparam int unsigned NumTypes   = 10;

  typedef logic [11:0] msg_type_t;
  typedef logic [NumTypes-1:0] type_mask_t;

  localparam msg_type_t KnownTypes [NumTypes] = '{
    12'd1005, 12'd1074, 12'd1077, 12'd1084, 12'd1087,
    12'd1094, 12'd1097, 12'd1124, 12'd1127, 12'd1230
  };

  typedef enum logic [6:0] {
    PhHunt    = 7'b0000001,
    PhHdr1    = 7'b0000010,
    PhHdr2    = 7'b0000100,
    PhPayload = 7'b0001000,
    PhCrc1    = 7'b0010000,
    PhCrc2    = 7'b0100000,
    PhCrc3    = 7'b1000000
  } phase_e;

  // Per-byte frame outcome passed from the parser to the top level.
  typedef struct packed {
    logic       frame_end;
    logic       crc_good;
    msg_type_t  message_type;
    logic       type_known;
    type_mask_t type_hit;
  } frame_evt_t;

  // CRC-24Q update over one byte, most significant bit first.
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_in,
                                              input logic [7:0]  b);
    logic [23:0] c;
    logic        msb;
    c = crc_in ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      msb = c[23];
      c   = {c[22:0], 1'b0} ^ (msb ? Crc24qPoly : 24'h000000);
    end
    return c;
  endfunction

  // One-hot match of a message type against the supported list.
  function automatic type_mask_t type_lookup(input msg_type_t t);
    type_mask_t hit;
    hit = '0;
    for (int i = 0; i < NumTypes; i++) begin
      hit[i] = (t == KnownTypes[i]);
    end
    return hit;
  endfunction

endpackage

// ===== hw/rtl/rtcm3_ftm_parser.sv =====
// Byte-serial RTCM3 frame parser with CRC-24Q check and message type extraction.
module rtcm3_ftm_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               data_byte_i,
  output rtcm3_ftm_pkg::frame_evt_t evt_o
);
  import rtcm3_ftm_pkg::*;

  phase_e      phase_q, phase_d;
  logic [9:0]  len_q, len_d;
  logic [9:0]  count_q, count_d;
  logic [23:0] crc_q, crc_d;
  logic [15:0] rx_q, rx_d;
  msg_type_t   type_q, type_d;

  logic [23:0] crc_upd;
  logic [9:0]  count_inc;
  logic [9:0]  len_full;
  logic        good;
  logic        long_enough;
  type_mask_t  hit;

  assign crc_upd     = crc24q_byte(crc_q, data_byte_i);
  assign count_inc   = count_q + 10'd1;
  assign len_full    = {len_q[9:8], data_byte_i};
  assign good        = ({rx_q, data_byte_i} == crc_q);
  assign long_enough = (len_q >= 10'd2);
  assign hit         = type_lookup(type_q);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    count_d = count_q;
    crc_d   = crc_q;
    rx_d    = rx_q;
    type_d  = type_q;
    evt_o   = '0;
    case (phase_q)
      PhHdr1: begin
        crc_d   = crc_upd;
        len_d   = {data_byte_i[1:0], 8'h00};
        phase_d = PhHdr2;
      end
      PhHdr2: begin
        crc_d   = crc_upd;
        len_d   = len_full;
        count_d = '0;
        type_d  = '0;
        phase_d = (len_full == 10'd0) ? PhCrc1 : PhPayload;
      end
      PhPayload: begin
        crc_d = crc_upd;
        if (count_q == 10'd0) begin
          type_d = {data_byte_i, 4'h0};
        end else if (count_q == 10'd1) begin
          type_d = {type_q[11:4], data_byte_i[7:4]};
        end
        count_d = count_inc;
        if (count_inc >= len_q) begin
          phase_d = PhCrc1;
        end
      end
      PhCrc1: begin
        rx_d    = {data_byte_i, 8'h00};
        phase_d = PhCrc2;
      end
      PhCrc2: begin
        rx_d    = {rx_q[15:8], data_byte_i};
        phase_d = PhCrc3;
      end
      PhCrc3: begin
        evt_o.frame_end = 1'b1;
        evt_o.crc_good  = good;
        if (long_enough) begin
          evt_o.message_type = type_q;
          evt_o.type_known   = good && (hit != '0);
          evt_o.type_hit     = good ? hit : '0;
        end
        phase_d = PhHunt;
      end
      default: begin
        // Hunting, and any unreachable code, looks for the preamble.
        if (data_byte_i == Preamble) begin
          crc_d   = crc24q_byte(24'h000000, data_byte_i);
          phase_d = PhHdr1;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      count_q <= '0;
      crc_q   <= '0;
      rx_q    <= '0;
      type_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      rx_q    <= rx_d;
      type_q  <= type_d;
    end
  end

endmodule

// ===== hw/rtl/rtcm3_frame_type_monitor.sv =====
// Top level of the RTCM3 frame type monitor: handshakes, sticky type mask, result register.
//
// The monitor takes one transfer per clock cycle on its input channel while
// in_ready_o is high, either a stream byte (cmd_i low) or a consume command
// (cmd_i high), and answers every transfer with exactly one result, presented
// from the output register on the cycle after the input transfer. The input
// side stays ready whenever the output register is empty or is being emptied
// in the same cycle, so with a ready consumer a byte enters every cycle; the
// byte-wide CRC-24Q update network and the frame state update are both
// combinational, in front of the parser registers. Each byte
// advances the frame parser: it hunts for the 0xD3 preamble, reads the 10-bit
// payload length, runs CRC-24Q over preamble, header and payload, and on the
// last of the three trailing CRC bytes reports frame_end_o, crc_good_o, the
// 12-bit message type and whether the type is one of the ten supported ones.
// Frames with a bad CRC are skipped whole; hunting resumes after their last
// CRC byte. Supported types seen in good frames set bits of a sticky mask
// (bits 0 to 9 for 1005, 1074, 1077, 1084, 1087, 1094, 1097, 1124, 1127 and
// 1230). A consume command returns the mask as it stood and clears it,
// leaving the parser untouched.
module rtcm3_frame_type_monitor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [7:0]                data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rtcm3_ftm_pkg::type_mask_t type_mask_o,
  output logic                      frame_end_o,
  output logic                      crc_good_o,
  output rtcm3_ftm_pkg::msg_type_t  message_type_o,
  output logic                      type_known_o
);
  import rtcm3_ftm_pkg::*;

  logic       in_xfer;
  logic       byte_step;
  frame_evt_t evt;

  type_mask_t mask_q, mask_d;
  logic       out_valid_q, out_valid_d;
  type_mask_t res_mask_q, res_mask_d;
  frame_evt_t res_evt_q, res_evt_d;

  // The input side is free whenever the result register is empty or is
  // handed on in this very cycle, so a stalled consumer costs nothing more.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign byte_step  = in_xfer && !cmd_i;

  rtcm3_ftm_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (byte_step),
    .data_byte_i (data_byte_i),
    .evt_o       (evt)
  );

  always_comb begin
    mask_d      = mask_q;
    res_mask_d  = res_mask_q;
    res_evt_d   = res_evt_q;
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      if (cmd_i) begin
        // Consume: report the mask as it stood, then clear it.
        res_mask_d = mask_q;
        res_evt_d  = '0;
        mask_d     = '0;
      end else begin
        mask_d     = mask_q | evt.type_hit;
        res_mask_d = mask_q | evt.type_hit;
        res_evt_d  = evt;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    res_mask_q <= res_mask_d;
    res_evt_q  <= res_evt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign type_mask_o    = res_mask_q;
  assign frame_end_o    = res_evt_q.frame_end;
  assign crc_good_o     = res_evt_q.crc_good;
  assign message_type_o = res_evt_q.message_type;
  assign type_known_o   = res_evt_q.type_known;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RTCM3 frame type monitor.
module tb;
  import rtcm3_ftm_pkg::*;

  // Command codes carried on cmd_i.
  localparam logic CmdByte    = 1'b0;
  localparam logic CmdConsume = 1'b1;

  // CRC-24Q generator including the x^24 term, so that the carry out of the
  // shift is cleared by the same XOR that folds the polynomial in.
  localparam logic [24:0] Crc24qGen = 25'h1864CFB;

  // Supported message types, in mask bit order.
  localparam msg_type_t SupportedTypes [10] = '{
    12'd1005, 12'd1074, 12'd1077, 12'd1084, 12'd1087,
    12'd1094, 12'd1097, 12'd1124, 12'd1127, 12'd1230
  };

  // Number of counted random transfers after the directed part.
  localparam int unsigned RandomItems = 210;

  // One result transfer as the monitor should present it.
  typedef struct packed {
    type_mask_t mask;
    logic       frame_end;
    logic       crc_good;
    msg_type_t  msg_type;
    logic       type_known;
  } frame_report_t;

  // CRC-24Q over one byte, most significant bit first, held in 25 bits so
  // that the bit shifted out can be tested directly.
  function automatic logic [23:0] crc24q_next(input logic [23:0] crc_in,
                                              input logic [7:0]  b);
    logic [24:0] acc;
    acc = {1'b0, crc_in ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      acc = acc << 1;
      if (acc[24]) begin
        acc = acc ^ Crc24qGen;
      end
    end
    return acc[23:0];
  endfunction

  // The scoreboard carries its own copy of the frame parser. Every accepted
  // input transfer advances it and leaves one expected report behind; every
  // output transfer is checked against the oldest of those.
  class frame_report_board;
    phase_e          parse_phase;
    logic [9:0]      frame_len;
    logic [9:0]      payload_seen;
    logic [23:0]     running_crc;
    logic [23:0]     trailing_crc;
    msg_type_t       type_field;
    type_mask_t      seen_types;
    frame_report_t   expected_reports [$];
    int unsigned     failures;
    int unsigned     mismatches;
    int unsigned     reports_checked;
    int unsigned     frames_closed;
    int unsigned     frames_good;
    int unsigned     types_hit;
    int unsigned     consumes;

    function new();
      parse_phase     = PhHunt;
      frame_len       = '0;
      payload_seen    = '0;
      running_crc     = '0;
      trailing_crc    = '0;
      type_field      = '0;
      seen_types      = '0;
      failures        = 0;
      mismatches      = 0;
      reports_checked = 0;
      frames_closed   = 0;
      frames_good     = 0;
      types_hit       = 0;
      consumes        = 0;
    endfunction

    function void note_transfer(input logic cmd, input logic [7:0] b);
      frame_report_t rep;
      int            hit;
      rep = '0;
      hit = -1;
      if (cmd == CmdConsume) begin
        // The mask goes out as it stood, then clears; the parser is left alone.
        rep.mask   = seen_types;
        seen_types = '0;
        consumes++;
      end else begin
        case (parse_phase)
          PhHdr1: begin
            running_crc = crc24q_next(running_crc, b);
            frame_len   = {b[1:0], 8'h00};
            parse_phase = PhHdr2;
          end
          PhHdr2: begin
            running_crc    = crc24q_next(running_crc, b);
            frame_len[7:0] = b;
            payload_seen   = '0;
            type_field     = '0;
            parse_phase    = (frame_len == 10'd0) ? PhCrc1 : PhPayload;
          end
          PhPayload: begin
            running_crc = crc24q_next(running_crc, b);
            if (payload_seen == 10'd0) begin
              type_field = {b, 4'h0};
            end else if (payload_seen == 10'd1) begin
              type_field[3:0] = b[7:4];
            end
            payload_seen = payload_seen + 10'd1;
            if (payload_seen >= frame_len) begin
              parse_phase = PhCrc1;
            end
          end
          PhCrc1: begin
            trailing_crc = {b, 16'h0000};
            parse_phase  = PhCrc2;
          end
          PhCrc2: begin
            trailing_crc[15:8] = b;
            parse_phase        = PhCrc3;
          end
          PhCrc3: begin
            trailing_crc[7:0] = b;
            rep.frame_end     = 1'b1;
            rep.crc_good      = (trailing_crc == running_crc);
            frames_closed++;
            if (rep.crc_good) begin
              frames_good++;
            end
            if (frame_len >= 10'd2) begin
              rep.msg_type = type_field;
              foreach (SupportedTypes[i]) begin
                if (SupportedTypes[i] == type_field) begin
                  hit = i;
                end
              end
              if (rep.crc_good && hit >= 0) begin
                rep.type_known  = 1'b1;
                seen_types[hit] = 1'b1;
                types_hit++;
              end
            end
            parse_phase = PhHunt;
          end
          default: begin
            if (b == Preamble) begin
              running_crc = crc24q_next(24'h000000, b);
              parse_phase = PhHdr1;
            end else begin
              parse_phase = PhHunt;
            end
          end
        endcase
        rep.mask = seen_types;
      end
      expected_reports.push_back(rep);
    endfunction

    function void check_report(input type_mask_t mask, input logic fend,
                               input logic good, input msg_type_t mtype,
                               input logic known);
      frame_report_t want;
      reports_checked++;
      if (expected_reports.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with no report expected", reports_checked);
        end
        return;
      end
      want = expected_reports.pop_front();
      if (mask !== want.mask || fend !== want.frame_end || good !== want.crc_good ||
          mtype !== want.msg_type || known !== want.type_known) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: expected mask %h end %b good %b type %0d known %b",
                   reports_checked, want.mask, want.frame_end, want.crc_good,
                   want.msg_type, want.type_known);
          $display("                     got      mask %h end %b good %b type %0d known %b",
                   mask, fend, good, mtype, known);
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_reports.size();
    endfunction
  endclass

  // Clock, reset and the monitor's inputs. Every input holds a known value
  // from time zero; reset starts low and is released just after a falling edge.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       cmd_i       = CmdByte;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_ready_i = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  type_mask_t type_mask_o;
  logic       frame_end_o;
  logic       crc_good_o;
  msg_type_t  message_type_o;
  logic       type_known_o;

  frame_report_board board;
  int unsigned       items_sent;
  int unsigned       results_got;

  rtcm3_frame_type_monitor DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .type_mask_o    (type_mask_o),
    .frame_end_o    (frame_end_o),
    .crc_good_o     (crc_good_o),
    .message_type_o (message_type_o),
    .type_known_o   (type_known_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle cycles to insert before the n-th transfer on either side. Every
  // third block of a hundred transfers runs back to back with no idling, so
  // that full-rate streaming is exercised as well as ragged traffic.
  function automatic int unsigned idle_cycles(input int unsigned n);
    if ((n / 100) % 3 == 1) begin
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // Offers one input transfer. It is entered just after a falling edge, so
  // valid is either lowered for the idle gap or raised straight away, never
  // both in the same step. The transfer is noted with the scoreboard at the
  // rising edge where valid and ready meet, and the task returns on the
  // falling edge that follows.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = idle_cycles(items_sent);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    board.note_transfer(cmd, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Builds a frame with a correct CRC-24Q trailer and sends it. The first two
  // payload bytes carry the message type in their top twelve bits. A frame
  // can be damaged by flipping one bit of the byte at flip_at, or cut short
  // after cut_at bytes; with sprinkle set, consume commands are dropped in
  // between bytes now and then, which must leave the parse undisturbed.
  task automatic send_frame(input logic [9:0] len, input msg_type_t mtype,
                            input logic [5:0] rsv, input int flip_at,
                            input int cut_at, input bit sprinkle);
    logic [7:0]  frame_bytes [$];
    logic [23:0] crc;
    frame_bytes.push_back(Preamble);
    frame_bytes.push_back({rsv, len[9:8]});
    frame_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        frame_bytes.push_back(mtype[11:4]);
      end else if (i == 1) begin
        frame_bytes.push_back({mtype[3:0], 4'($urandom_range(0, 15))});
      end else begin
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    crc = 24'h000000;
    foreach (frame_bytes[i]) begin
      crc = crc24q_next(crc, frame_bytes[i]);
    end
    frame_bytes.push_back(crc[23:16]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    if (flip_at >= 0) begin
      frame_bytes[flip_at] = frame_bytes[flip_at] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (cut_at >= 0) begin
      while (frame_bytes.size() > cut_at) begin
        void'(frame_bytes.pop_back());
      end
    end
    foreach (frame_bytes[i]) begin
      if (sprinkle && $urandom_range(0, 29) == 0) begin
        send_item(CmdConsume, 8'($urandom_range(0, 255)));
      end
      send_item(CmdByte, frame_bytes[i]);
    end
  endtask

  // Result side. Each result waits an idle gap from idle_cycles with ready low;
  // once, after 150 results, ready is held low while the sender
  // keeps offering, so the output register fills and the input is stalled.
  initial begin : result_side
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = (results_got == 150) ? 80 : idle_cycles(results_got);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      board.check_report(type_mask_o, frame_end_o, crc_good_o, message_type_o,
                         type_known_o);
      results_got++;
      @(negedge clk_i);
    end
  end

  // Input side and end of run.
  initial begin : input_side
    int unsigned base;
    int unsigned noise_bytes;
    int unsigned pick;
    int unsigned sel;
    logic [9:0]  len;
    msg_type_t   mtype;
    logic [5:0]  rsv;
    board       = new();
    items_sent  = 0;
    results_got = 0;
    noise_bytes = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. A consume on an empty mask, a stray byte while hunting,
    // an empty payload with all reserved header bits set, a one-byte payload
    // whose last CRC byte is damaged, a good frame of the last supported
    // type, and a consume that must return and clear that type's bit.
    send_item(CmdConsume, 8'hFF);
    send_item(CmdByte, 8'hFF);
    send_frame(10'd0, 12'd0, 6'h3F, -1, -1, 1'b0);
    send_frame(10'd1, 12'hFFF, 6'h00, 7 - 1, -1, 1'b0);
    send_frame(10'd2, SupportedTypes[9], 6'h00, -1, -1, 1'b0);
    send_item(CmdConsume, 8'h00);

    // A long payload whose length needs the upper header bits, of a
    // supported type.
    send_frame(10'd300, SupportedTypes[8], 6'h15, -1, -1, 1'b1);

    // Random part: mostly well-formed frames with random content, mixed with
    // damaged frames, cut-short frames, line noise and bare consumes. Noise
    // bytes do not count towards the number of random transfers.
    base = items_sent;
    while (items_sent - noise_bytes - base < RandomItems) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 9);
      len  = (sel == 0) ? 10'd0 : (sel == 1) ? 10'd1 :
             (sel == 2) ? 10'($urandom_range(9, 40)) : 10'($urandom_range(2, 8));
      mtype = ($urandom_range(0, 9) < 6) ? SupportedTypes[$urandom_range(0, 9)] :
              12'($urandom_range(0, 4095));
      rsv  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'h00;
      if (pick < 70) begin
        send_frame(len, mtype, rsv, -1, -1, 1'b1);
      end else if (pick < 80) begin
        send_frame(len, mtype, rsv, $urandom_range(0, len + 5), -1, 1'b1);
      end else if (pick < 88) begin
        send_frame(len, mtype, rsv, -1, $urandom_range(1, len + 5), 1'b1);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(CmdByte, 8'($urandom_range(0, 255)));
          noise_bytes++;
        end
      end else begin
        send_item(CmdConsume, 8'($urandom_range(0, 255)));
      end
    end
    in_valid_i <= 1'b0;

    // Drain every outstanding report, then keep watching for any stray
    // result before judging the run.
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d transfers with %0d consumes; %0d results checked.",
             items_sent, board.consumes, board.reports_checked);
    $display("Frames closed %0d, CRC good %0d, supported types recorded %0d.",
             board.frames_closed, board.frames_good, board.types_hit);
    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rtcm3_ftm_pkg.sv
hw/rtl/rtcm3_ftm_parser.sv
hw/rtl/rtcm3_frame_type_monitor.sv
tb/tb.sv
